FILE: src/sprq_pkg.sv
package sprq_pkg;

  // Command codes.
  localparam logic [1:0] CMD_MAKE_READY = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE   = 2'd1;
  localparam logic [1:0] CMD_SUSPEND    = 2'd2;
  localparam logic [1:0] CMD_SET_PRIO   = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_RUNNABLE = 2'd1;
  localparam logic [1:0] ERR_SUSPEND  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // Thread status codes.
  localparam logic [1:0] ST_BLOCKED = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUN     = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] thread_id;
    logic [2:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [5:0] running_thread;
    logic       running_valid;
    logic [1:0] error_code;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic read;
    logic exec;
    logic pop;
    logic fin;
    logic finish;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sched;
  } sts_t;

endpackage

FILE: src/sprq_ctrl.sv
module sprq_ctrl
  import sprq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output ctl_t ctl_o,
  output logic busy_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_POP  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state: schedule-type commands pass through the pop steps.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: state_d = sts_i.is_sched ? S_POP : S_IDLE;
      S_POP:  state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command decode for the datapath.
  always_comb begin
    ctl_o.accept = (state_q == S_IDLE) && start_i;
    ctl_o.read   = (state_q == S_READ);
    ctl_o.exec   = (state_q == S_EXEC);
    ctl_o.pop    = (state_q == S_POP);
    ctl_o.fin    = (state_q == S_FIN);
    ctl_o.finish = ((state_q == S_EXEC) && !sts_i.is_sched) || (state_q == S_FIN);
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: src/sprq_datapath.sv
module sprq_datapath
  import sprq_pkg::*;
#(
  parameter int NUM_LEVELS  = 8,
  parameter int NUM_THREADS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  cmd_i,
  input  ctl_t ctl_i,
  output sts_t sts_o,
  output out_t res_o,
  output logic done_o
);

  localparam int TW = $clog2(NUM_THREADS);
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CW = $clog2(NUM_THREADS + 1);

  // Latched command.
  logic [1:0] command_q;
  logic [5:0] tid_q;

  // Running thread.
  logic [TW-1:0] cur_q;
  logic          cv_q;
  logic [1:0]    err_q;

  // Per-level FIFO pointers.
  logic [TW-1:0] head_q [NUM_LEVELS];
  logic [TW-1:0] tail_q [NUM_LEVELS];
  logic [CW-1:0] cnt_q  [NUM_LEVELS];

  // Thread tables with valid bits standing in for their reset values.
  logic [1:0]    stat_mem [NUM_THREADS];
  logic [LW-1:0] prio_mem [NUM_THREADS];
  logic [NUM_THREADS-1:0] stat_vld_q, prio_vld_q;
  logic [1:0]    stat_rd_q;
  logic [LW-1:0] prio_rd_q;
  logic          statv_rd_q, priov_rd_q;

  // Queue slot memory.
  logic [TW-1:0] slot_mem [NUM_LEVELS][NUM_THREADS];
  logic [TW-1:0] slot_rd_q;
  logic          found_q;

  logic          is_mr, is_susp, tid_ok, runnable, full, push_en, prio_we;
  logic [TW-1:0] rd_addr, push_id, tid_t;
  logic [1:0]    stat_now, exec_err, stat_wd;
  logic [LW-1:0] prio_now, prio_sat;
  logic          stat_we;
  logic [TW-1:0] stat_wa;
  logic          any_ne;
  logic [LW-1:0] pop_lvl;
  out_t          res_q;
  logic          done_q;

  assign tid_t   = TW'(tid_q);
  assign tid_ok  = int'(tid_q) < NUM_THREADS;
  assign is_mr   = (command_q == CMD_MAKE_READY);
  assign is_susp = (command_q == CMD_SUSPEND);
  assign sts_o.is_sched = (command_q == CMD_SCHEDULE) || (command_q == CMD_SET_PRIO);

  // Latch the command on transfer.
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      command_q <= cmd_i.command;
      tid_q     <= cmd_i.thread_id;
    end
  end

  // Priority write of set_priority happens at the transfer itself.
  assign prio_sat = (int'(cmd_i.priority_req) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                              : LW'(cmd_i.priority_req);
  assign prio_we  = ctl_i.accept && (cmd_i.command == CMD_SET_PRIO)
                    && (int'(cmd_i.thread_id) < NUM_THREADS);

  always_ff @(posedge clk_i) begin
    if (prio_we) begin
      prio_mem[TW'(cmd_i.thread_id)] <= prio_sat;
    end
  end

  // Table reads of the addressed thread.
  assign rd_addr = is_mr ? tid_t : cur_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.read) begin
      stat_rd_q  <= stat_mem[rd_addr];
      prio_rd_q  <= prio_mem[rd_addr];
      statv_rd_q <= stat_vld_q[rd_addr];
      priov_rd_q <= prio_vld_q[rd_addr];
    end
  end

  assign stat_now = statv_rd_q ? stat_rd_q : ST_BLOCKED;
  assign prio_now = priov_rd_q ? prio_rd_q : '0;
  assign runnable = (stat_now == ST_READY) || (stat_now == ST_RUN);
  assign full     = (int'(cnt_q[prio_now]) >= NUM_THREADS);
  assign push_id  = is_mr ? tid_t : cur_q;

  // Execute step: checks, requeue or enqueue, error code; dispatch marks the new thread running.
  always_comb begin
    push_en  = 1'b0;
    exec_err = ERR_OK;
    stat_we  = 1'b0;
    stat_wa  = push_id;
    stat_wd  = ST_READY;
    if (ctl_i.exec) begin
      priority if (is_mr) begin
        if (!tid_ok || runnable) begin
          exec_err = ERR_RUNNABLE;
        end else if (full) begin
          exec_err = ERR_OVERFLOW;
        end else begin
          push_en = 1'b1;
          stat_we = 1'b1;
        end
      end else if (is_susp) begin
        if (!cv_q || !runnable) begin
          exec_err = ERR_SUSPEND;
        end else begin
          stat_we = 1'b1;
          stat_wd = ST_BLOCKED;
        end
      end else begin
        if (cv_q && runnable) begin
          stat_we = 1'b1;
          if (full) begin
            exec_err = ERR_OVERFLOW;
            stat_wd  = ST_BLOCKED;
          end else begin
            push_en = 1'b1;
          end
        end
      end
    end else if (ctl_i.fin && found_q) begin
      stat_we = 1'b1;
      stat_wa = slot_rd_q;
      stat_wd = ST_RUN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_we) begin
      stat_mem[stat_wa] <= stat_wd;
    end
  end

  // Lowest-numbered nonempty level.
  always_comb begin
    any_ne  = 1'b0;
    pop_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        any_ne  = 1'b1;
        pop_lvl = LW'(i);
      end
    end
  end

  // Slot memory write on push, read on pop.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      slot_mem[prio_now][tail_q[prio_now]] <= push_id;
    end
    if (ctl_i.pop) begin
      slot_rd_q <= slot_mem[pop_lvl][head_q[pop_lvl]];
    end
  end

  // Control state: valid bits, pointers, running thread.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_vld_q <= '0;
      prio_vld_q <= '0;
      cur_q      <= '0;
      cv_q       <= 1'b0;
      found_q    <= 1'b0;
      err_q      <= ERR_OK;
      done_q     <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      done_q <= ctl_i.finish;
      if (stat_we) stat_vld_q[stat_wa] <= 1'b1;
      if (prio_we) prio_vld_q[TW'(cmd_i.thread_id)] <= 1'b1;
      if (ctl_i.exec) err_q <= exec_err;
      if (push_en) begin
        tail_q[prio_now] <= (int'(tail_q[prio_now]) == NUM_THREADS - 1) ? '0
                            : tail_q[prio_now] + 1'b1;
        cnt_q[prio_now]  <= cnt_q[prio_now] + 1'b1;
      end
      if (ctl_i.pop) begin
        found_q <= any_ne;
        if (any_ne) begin
          head_q[pop_lvl] <= (int'(head_q[pop_lvl]) == NUM_THREADS - 1) ? '0
                             : head_q[pop_lvl] + 1'b1;
          cnt_q[pop_lvl]  <= cnt_q[pop_lvl] - 1'b1;
        end
      end
      if (ctl_i.fin) begin
        cv_q  <= found_q;
        cur_q <= found_q ? slot_rd_q : '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      if (ctl_i.fin) begin
        res_q.running_thread <= found_q ? 6'(slot_rd_q) : 6'd0;
        res_q.running_valid  <= found_q;
        res_q.error_code     <= err_q;
      end else begin
        res_q.running_thread <= cv_q ? 6'(cur_q) : 6'd0;
        res_q.running_valid  <= cv_q;
        res_q.error_code     <= exec_err;
      end
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

FILE: src/strict_priority_ready_queue_unit.sv
// Strict-priority ready queue for one core.
// Input channel: a command (make_ready, schedule, suspend, set_priority)
// is transferred at a rising edge with start_i high and busy_o low.
// Output channel: done_o is high for exactly one cycle with the result on
// res_o (running thread, valid flag, error code); the receiver cannot stall,
// so every result is taken in its strobe cycle.
// Steps: make_ready and suspend end after the table read and execute step;
// schedule and set_priority run all of table read, requeue, pop, dispatch;
// the strobe follows in the cycle after the last step. busy_o drops as the
// strobe rises, so a new command can be issued in the strobe cycle; commands
// never overlap. The step count is set by the single-port thread tables and
// the slot memory, each with a registered read.
// Reset clears all queue pointers and counts, marks every thread blocked
// at priority 0 and leaves the core idle; it takes effect at once.
module strict_priority_ready_queue_unit
  import sprq_pkg::*;
#(
  parameter int NUM_LEVELS  = 8,
  parameter int NUM_THREADS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t  cmd_i,
  output logic busy_o,
  output logic done_o,
  output out_t res_o
);

  ctl_t ctl;
  sts_t sts;

  sprq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy_o)
  );

  sprq_datapath #(
    .NUM_LEVELS (NUM_LEVELS),
    .NUM_THREADS(NUM_THREADS)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .res_o (res_o),
    .done_o(done_o)
  );

`ifndef ASSERT_OFF
  // A transfer starts a command that keeps the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("not busy after transfer");

  // A result only ends a command.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) && !busy_o)) else $error("stray result");

  // An idle core reports thread zero.
  a_idle_thread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.running_valid) |-> (res_o.running_thread == 6'd0))
    else $error("idle core with nonzero thread");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sprq_pkg::*;

  localparam int LEVELS  = 8;
  localparam int THREADS = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  in_t  cmd_i = '0;
  logic busy_o;
  logic done_o;
  out_t res_o;

  strict_priority_ready_queue_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #4 clk_i = ~clk_i;

  // Scheduler state mirrored by the predictor.
  logic [5:0] slot_mem [LEVELS][THREADS];
  int         lvl_head [LEVELS];
  int         lvl_tail [LEVELS];
  int         lvl_count[LEVELS];
  logic [1:0] thr_status[THREADS];
  logic [2:0] thr_prio  [THREADS];
  logic [5:0] cur_thread;
  logic       cur_valid;

  in_t  cmd_queue[$];
  int   gap_queue[$];
  out_t expected_results[$];
  int   errors = 0;
  int   err_seen[4];
  int   cmd_seen[4];
  bit   hold_for_drain = 1'b0;

  function automatic bit is_runnable(logic [5:0] t);
    return thr_status[t] == ST_READY || thr_status[t] == ST_RUN;
  endfunction

  function automatic bit level_push(int lvl, logic [5:0] t);
    if (lvl_count[lvl] >= THREADS) return 1'b0;
    slot_mem[lvl][lvl_tail[lvl]] = t;
    lvl_tail[lvl] = (lvl_tail[lvl] + 1) % THREADS;
    lvl_count[lvl]++;
    return 1'b1;
  endfunction

  // Requeue the running thread if still runnable, then dispatch the most urgent.
  function automatic logic [1:0] dispatch_next();
    logic [1:0] err;
    logic [5:0] t;
    err = ERR_OK;
    if (cur_valid && is_runnable(cur_thread)) begin
      if (level_push(int'(thr_prio[cur_thread]), cur_thread)) begin
        thr_status[cur_thread] = ST_READY;
      end else begin
        thr_status[cur_thread] = ST_BLOCKED;
        err = ERR_OVERFLOW;
      end
    end
    cur_valid = 1'b0;
    cur_thread = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lvl_count[l] != 0) begin
        t = slot_mem[l][lvl_head[l]];
        lvl_head[l] = (lvl_head[l] + 1) % THREADS;
        lvl_count[l]--;
        thr_status[t] = ST_RUN;
        cur_thread = t;
        cur_valid = 1'b1;
        break;
      end
    end
    return err;
  endfunction

  function automatic out_t predict_command(in_t c);
    out_t r;
    logic [1:0] err;
    err = ERR_OK;
    case (c.command)
      CMD_MAKE_READY: begin
        if (is_runnable(c.thread_id)) begin
          err = ERR_RUNNABLE;
        end else if (level_push(int'(thr_prio[c.thread_id]), c.thread_id)) begin
          thr_status[c.thread_id] = ST_READY;
        end else begin
          err = ERR_OVERFLOW;
        end
      end
      CMD_SCHEDULE: err = dispatch_next();
      CMD_SUSPEND: begin
        if (!cur_valid || !is_runnable(cur_thread)) err = ERR_SUSPEND;
        else thr_status[cur_thread] = ST_BLOCKED;
      end
      default: begin
        thr_prio[c.thread_id] = c.priority_req;
        err = dispatch_next();
      end
    endcase
    r.running_thread = cur_valid ? cur_thread : 6'd0;
    r.running_valid = cur_valid;
    r.error_code = err;
    return r;
  endfunction

  function automatic in_t mk(logic [1:0] c, int t, int p);
    in_t x;
    x.command = c;
    x.thread_id = t[5:0];
    x.priority_req = p[2:0];
    return x;
  endfunction

  task automatic add_item(in_t x, int gap);
    cmd_queue.push_back(x);
    gap_queue.push_back(gap);
  endtask

  // Driver: waits a drawn gap, then holds start until the transfer happens.
  int wait_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        void'(cmd_queue.pop_front());
        void'(gap_queue.pop_front());
        cmd_seen[cmd_i.command]++;
        expected_results.push_back(predict_command(cmd_i));
      end
      if (start_i && busy_o) begin
        // still waiting for the transfer
      end else if (cmd_queue.size() == 0) begin
        start_i <= 1'b0;
      end else if (hold_for_drain && expected_results.size() +
                   ((start_i && !busy_o) ? 1 : 0) > 0) begin
        start_i <= 1'b0;
      end else if (!(start_i && !busy_o) && wait_cnt < gap_queue[0]) begin
        wait_cnt <= wait_cnt + 1;
        start_i <= 1'b0;
      end else if (start_i && !busy_o && gap_queue.size() > 0 && gap_queue[0] > 0) begin
        wait_cnt <= 1;
        start_i <= 1'b0;
      end else begin
        wait_cnt <= 0;
        start_i <= 1'b1;
        cmd_i <= cmd_queue[0];
      end
    end
  end

  // Monitor: each strobe is checked against the oldest expected result.
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", res_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        err_seen[e.error_code]++;
        if (res_o.running_thread !== e.running_thread) begin
          $error("running_thread expected %0d actual %0d", e.running_thread,
                 res_o.running_thread);
          errors++;
        end
        if (res_o.running_valid !== e.running_valid) begin
          $error("running_valid expected %0d actual %0d", e.running_valid,
                 res_o.running_valid);
          errors++;
        end
        if (res_o.error_code !== e.error_code) begin
          $error("error_code expected %0d actual %0d", e.error_code, res_o.error_code);
          errors++;
        end
      end
    end
  end

  initial begin
    int r, t, gap;
    for (int l = 0; l < LEVELS; l++) begin
      lvl_head[l] = 0;
      lvl_tail[l] = 0;
      lvl_count[l] = 0;
    end
    for (int i = 0; i < THREADS; i++) begin
      thr_status[i] = ST_BLOCKED;
      thr_prio[i] = '0;
    end
    cur_thread = '0;
    cur_valid = 1'b0;
    for (int i = 0; i < 4; i++) begin
      err_seen[i] = 0;
      cmd_seen[i] = 0;
    end

    // Directed: idle schedule, suspend while idle, extremes, duplicate ready.
    add_item(mk(CMD_SCHEDULE, 0, 0), 0);
    add_item(mk(CMD_SUSPEND, 0, 0), 0);
    add_item(mk(CMD_MAKE_READY, 63, 7), 0);
    add_item(mk(CMD_MAKE_READY, 63, 0), 1);
    add_item(mk(CMD_MAKE_READY, 0, 0), 0);
    add_item(mk(CMD_SET_PRIO, 63, 7), 0);
    add_item(mk(CMD_SCHEDULE, 0, 0), 2);
    add_item(mk(CMD_MAKE_READY, 0, 0), 0);
    add_item(mk(CMD_SUSPEND, 0, 0), 0);
    add_item(mk(CMD_SUSPEND, 0, 0), 0);
    add_item(mk(CMD_SCHEDULE, 0, 0), 0);
    add_item(mk(CMD_SET_PRIO, 21, 5), 3);
    add_item(mk(CMD_SET_PRIO, 42, 2), 0);
    add_item(mk(CMD_SCHEDULE, 0, 0), 9);
    add_item(mk(CMD_SUSPEND, 0, 0), 0);
    add_item(mk(CMD_SCHEDULE, 0, 0), 0);

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random part: mostly ready/schedule traffic with random content.
    for (int i = 0; i < 1200; i++) begin
      r = $urandom_range(0, 99);
      t = $urandom_range(0, 63);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
      if ((i / 200) % 2 == 1) gap = 0;
      if (r < 40) add_item(mk(CMD_MAKE_READY, t, $urandom_range(0, 7)), gap);
      else if (r < 65) add_item(mk(CMD_SCHEDULE, t, $urandom_range(0, 7)), gap);
      else if (r < 80) add_item(mk(CMD_SUSPEND, t, $urandom_range(0, 7)), gap);
      else add_item(mk(CMD_SET_PRIO, t, $urandom_range(0, 7)), gap);
      if (i == 700) begin
        wait (cmd_queue.size() <= 20);
        hold_for_drain = 1'b1;
        wait (cmd_queue.size() == 0 || expected_results.size() == 0);
        @(posedge clk_i);
        hold_for_drain = 1'b0;
      end
    end

    // Fill one level to overflow: all threads at level 6, then one requeue too many.
    for (int i = 0; i < THREADS; i++) add_item(mk(CMD_SUSPEND, 0, 0), 0);
    for (int i = 0; i < THREADS; i++) add_item(mk(CMD_SET_PRIO, i, 6), 0);
    for (int i = 0; i < THREADS; i++) add_item(mk(CMD_SUSPEND, 0, 0), 0);
    for (int i = 0; i < THREADS; i++) add_item(mk(CMD_MAKE_READY, i, 0), $urandom_range(0, 1));
    add_item(mk(CMD_SCHEDULE, 0, 0), 0);
    add_item(mk(CMD_MAKE_READY, 0, 0), 0);
    for (int i = 0; i < 20; i++) add_item(mk(CMD_SCHEDULE, 0, 0), 0);

    wait (cmd_queue.size() == 0);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d make_ready, %0d schedule, %0d suspend, %0d set_priority commands;",
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("error codes seen: ok %0d, runnable %0d, suspend %0d, overflow %0d.",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
